// ===== rtl/alarm_contact_debounce_core_macros.svh =====
// Assertion macros shared by the alarm contact debounce RTL.
// Included by bare file name from the modules that check their own logic.
`ifndef ALARM_CONTACT_DEBOUNCE_CORE_MACROS_SVH
`define ALARM_CONTACT_DEBOUNCE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("acd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("acd assertion failed");

`endif

// ===== rtl/acd_pkg.sv =====
// Package for the alarm contact debounce block: widths, codes and the result type.
// No dependencies; used by the top level.
`timescale 1ns / 1ps
`default_nettype none

package acd_pkg;

    localparam int ACD_CHANNELS_DEF = 4;
    localparam int ACD_INPUT_BITS   = 4;
    localparam int ACD_ADDR_W       = 4;
    localparam int ACD_DATA_W       = 32;

    // A channel is set once its count of stable active samples exceeds this.
    localparam logic [2:0] ACD_DEBOUNCE_LIMIT = 3'd5;
    localparam logic [2:0] ACD_COUNT_MAX      = 3'd7;
    localparam logic [7:0] ACD_READY_MAX      = 8'hFF;

    // Item commands
    localparam logic [1:0] CMD_SAMPLE    = 2'd0;
    localparam logic [1:0] CMD_HALF_TICK = 2'd1;
    localparam logic [1:0] CMD_BUZZ_TICK = 2'd2;
    localparam logic [1:0] CMD_CLEAR     = 2'd3;

    // Channel states
    localparam logic [1:0] ST_CLEAR    = 2'd0;
    localparam logic [1:0] ST_DEBOUNCE = 2'd1;
    localparam logic [1:0] ST_SET      = 2'd2;

    // Channel options
    localparam logic [1:0] OPT_OFF    = 2'd0;
    localparam logic [1:0] OPT_NO     = 2'd1;
    localparam logic [1:0] OPT_NC     = 2'd2;
    localparam logic [1:0] OPT_IGNORE = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_ALARM_MODE      = 2'd0;
    localparam logic [1:0] REG_CHANNEL_OPTIONS = 2'd1;
    localparam logic [1:0] REG_BUZZER_SECONDS  = 2'd2;
    localparam logic [1:0] REG_HOLD_SECONDS    = 2'd3;

    typedef struct packed {
        logic [7:0] channel_states;
        logic [3:0] new_alarm_mask;
        logic       alarm_key_event;
        logic       led_on;
        logic [7:0] buzzer_left;
        logic [8:0] hold_left;
        logic [7:0] ready_count;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/acd_ifs.sv =====
// Valid/ready channel interfaces for the alarm contact debounce block.
// Declares its own field widths and does not import acd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface acd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] contact_bits;
    logic       remote_enable;

    modport source (output valid, command, contact_bits, remote_enable, input ready);
    modport sink   (input valid, command, contact_bits, remote_enable, output ready);
endinterface

interface acd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] channel_states;
    logic [3:0] new_alarm_mask;
    logic       alarm_key_event;
    logic       led_on;
    logic [7:0] buzzer_left;
    logic [8:0] hold_left;
    logic [7:0] ready_count;

    modport source (output valid, channel_states, new_alarm_mask, alarm_key_event, led_on,
                    buzzer_left, hold_left, ready_count, input ready);
    modport sink   (input valid, channel_states, new_alarm_mask, alarm_key_event, led_on,
                    buzzer_left, hold_left, ready_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/alarm_contact_debounce_core.sv =====
// Alarm contact debounce for up to four contacts, each wired to an input bit.
// Each item (contact sample or tick) is registered on entry and processed when it
// fires from the input register: its result is written to the output register and the channel
// state, timers and ready count are updated. One item is accepted every cycle
// unless the block stalls, and each result is registered. The block only
// stalls when the output register is full and not being taken, as the single
// update stage then cannot retire the item held in the input register.
// Configuration is an APB register file of four 32-bit registers at 0x0 to 0xC.
`timescale 1ns / 1ps
`default_nettype none

`include "alarm_contact_debounce_core_macros.svh"

module alarm_contact_debounce_core #(
    parameter int CHANNELS = acd_pkg::ACD_CHANNELS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    acd_in_if.sink                             i_in,
    acd_out_if.source                          o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [acd_pkg::ACD_ADDR_W-1:0] paddr,
    input  wire logic [acd_pkg::ACD_DATA_W-1:0] pwdata,
    output logic      [acd_pkg::ACD_DATA_W-1:0] prdata,
    output logic                               pready
);

    // Width that covers every processed channel and every input bit.
    localparam int LW    = (CHANNELS > acd_pkg::ACD_INPUT_BITS) ? CHANNELS
                                                                : acd_pkg::ACD_INPUT_BITS;
    localparam int LRC_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration registers
    logic       r_alarm_mode;
    logic [7:0] r_channel_options;
    logic [6:0] r_buzzer_seconds;
    logic [7:0] r_hold_seconds;
    logic       w_cfg_wr;
    logic [1:0] w_cfg_idx;

    // Input and output stages
    logic       r_in_valid;
    logic [1:0] r_in_cmd;
    logic [3:0] r_in_bits;
    logic       r_in_en;
    logic       r_out_valid;
    acd_pkg::t_result r_out;
    logic       w_fire;

    // Block state
    logic [1:0]       r_chan_state [CHANNELS];
    logic [2:0]       r_chan_count [CHANNELS];
    logic             r_prev_level [CHANNELS];
    logic             r_prev_seen  [CHANNELS];
    logic [LRC_W-1:0] r_last_chan;
    logic             r_last_valid;
    logic [7:0]       r_ready_total;
    logic [8:0]       r_hold_timer;
    logic [7:0]       r_buzzer_timer;
    logic             r_led;

    logic [1:0]       n_chan_state [CHANNELS];
    logic [2:0]       n_chan_count [CHANNELS];
    logic             n_prev_level [CHANNELS];
    logic             n_prev_seen  [CHANNELS];
    logic [LRC_W-1:0] n_last_chan;
    logic             n_last_valid;
    logic [7:0]       n_ready_total;
    logic [8:0]       n_hold_timer;
    logic [7:0]       n_buzzer_timer;
    logic             n_led;
    acd_pkg::t_result n_out;

    logic             w_any_set;

    // ---------------------------------------------------------------- APB
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = paddr[acd_pkg::ACD_ADDR_W-1:2];

    always_comb begin
        case (w_cfg_idx)
            acd_pkg::REG_ALARM_MODE:      prdata = acd_pkg::ACD_DATA_W'(r_alarm_mode);
            acd_pkg::REG_CHANNEL_OPTIONS: prdata = acd_pkg::ACD_DATA_W'(r_channel_options);
            acd_pkg::REG_BUZZER_SECONDS:  prdata = acd_pkg::ACD_DATA_W'(r_buzzer_seconds);
            acd_pkg::REG_HOLD_SECONDS:    prdata = acd_pkg::ACD_DATA_W'(r_hold_seconds);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_mode      <= 1'b1;
            r_channel_options <= '0;
            r_buzzer_seconds  <= '0;
            r_hold_seconds    <= '0;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                acd_pkg::REG_ALARM_MODE:      r_alarm_mode      <= pwdata[0];
                acd_pkg::REG_CHANNEL_OPTIONS: r_channel_options <= pwdata[7:0];
                acd_pkg::REG_BUZZER_SECONDS:  r_buzzer_seconds  <= pwdata[6:0];
                acd_pkg::REG_HOLD_SECONDS:    r_hold_seconds    <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- handshake
    assign w_fire     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_fire;

    always_comb begin
        w_any_set = 1'b0;
        for (int ch = 0; ch < CHANNELS; ch++) begin
            if (r_chan_state[ch] == acd_pkg::ST_SET) w_any_set = 1'b1;
        end
    end

    // ------------------------------------------------------ update logic
    // Channels are walked in order, so a release on a lower channel loads the
    // hold timer before a higher channel decides whether to load the buzzer.
    always_comb begin
        logic [LW-1:0]   v_levels;
        logic [2*LW-1:0] v_opts;
        logic [LW-1:0]   v_mask;
        logic [2*LW-1:0] v_states;
        logic            v_level;
        logic [1:0]      v_opt;
        logic            v_changed;
        logic            v_inactive;

        v_levels   = LW'(r_in_bits);
        v_opts     = (2*LW)'(r_channel_options);
        v_mask     = '0;
        v_states   = '0;
        v_level    = 1'b0;
        v_opt      = acd_pkg::OPT_OFF;
        v_changed  = 1'b0;
        v_inactive = 1'b0;

        n_chan_state   = r_chan_state;
        n_chan_count   = r_chan_count;
        n_prev_level   = r_prev_level;
        n_prev_seen    = r_prev_seen;
        n_last_chan    = r_last_chan;
        n_last_valid   = r_last_valid;
        n_ready_total  = r_ready_total;
        n_hold_timer   = r_hold_timer;
        n_buzzer_timer = r_buzzer_timer;
        n_led          = r_led;

        case (r_in_cmd)
            acd_pkg::CMD_SAMPLE: begin
                if (r_alarm_mode && r_in_en) begin
                    for (int ch = 0; ch < CHANNELS; ch++) begin
                        v_level    = v_levels[ch];
                        v_opt      = v_opts[2*ch +: 2];
                        v_changed  = !r_prev_seen[ch] || (v_level != r_prev_level[ch]);
                        v_inactive = (v_opt == acd_pkg::OPT_NO) ? v_level : !v_level;
                        if (v_opt == acd_pkg::OPT_OFF) begin
                            n_chan_state[ch] = acd_pkg::ST_CLEAR;
                            n_chan_count[ch] = '0;
                        end else if (v_opt == acd_pkg::OPT_IGNORE) begin
                            n_chan_count[ch] = '0;
                        end else if (v_changed || v_inactive) begin
                            if (r_chan_state[ch] == acd_pkg::ST_SET) begin
                                n_hold_timer = {r_hold_seconds, 1'b0};
                                n_led        = 1'b1;
                            end
                            n_chan_state[ch] = acd_pkg::ST_CLEAR;
                            n_chan_count[ch] = '0;
                        end else if (r_chan_state[ch] != acd_pkg::ST_SET) begin
                            if (r_chan_count[ch] != acd_pkg::ACD_COUNT_MAX) begin
                                n_chan_count[ch] = r_chan_count[ch] + 3'd1;
                            end
                            n_chan_state[ch] = acd_pkg::ST_DEBOUNCE;
                        end
                        if (n_chan_count[ch] > acd_pkg::ACD_DEBOUNCE_LIMIT
                                && n_chan_state[ch] == acd_pkg::ST_DEBOUNCE) begin
                            n_chan_state[ch] = acd_pkg::ST_SET;
                            n_chan_count[ch] = '0;
                            v_mask[ch]       = 1'b1;
                            if (!n_last_valid || n_last_chan != LRC_W'(ch)) begin
                                if (n_ready_total != acd_pkg::ACD_READY_MAX) begin
                                    n_ready_total = n_ready_total + 8'd1;
                                end
                                n_last_chan  = LRC_W'(ch);
                                n_last_valid = 1'b1;
                            end
                            if (n_buzzer_timer == '0 && n_hold_timer == '0) begin
                                n_buzzer_timer = {r_buzzer_seconds, 1'b0};
                            end
                            n_led = 1'b1;
                        end
                        n_prev_level[ch] = v_level;
                        n_prev_seen[ch]  = 1'b1;
                    end
                end
            end
            acd_pkg::CMD_HALF_TICK: begin
                if (r_hold_timer != '0) n_hold_timer = r_hold_timer - 9'd1;
                if (n_hold_timer == '0 && !w_any_set) begin
                    n_last_valid  = 1'b0;
                    n_last_chan   = '0;
                    n_ready_total = '0;
                    n_led         = 1'b0;
                end
            end
            acd_pkg::CMD_BUZZ_TICK: begin
                if (r_buzzer_timer != '0) n_buzzer_timer = r_buzzer_timer - 8'd1;
            end
            acd_pkg::CMD_CLEAR: begin
                for (int ch = 0; ch < CHANNELS; ch++) begin
                    n_chan_state[ch] = acd_pkg::ST_CLEAR;
                    n_chan_count[ch] = '0;
                end
            end
            default: ;
        endcase

        for (int ch = 0; ch < CHANNELS; ch++) begin
            v_states[2*ch +: 2] = n_chan_state[ch];
        end

        n_out.channel_states  = v_states[7:0];
        n_out.new_alarm_mask  = v_mask[3:0];
        n_out.alarm_key_event = (v_mask != '0);
        n_out.led_on          = n_led;
        n_out.buzzer_left     = n_buzzer_timer;
        n_out.hold_left       = n_hold_timer;
        n_out.ready_count     = n_ready_total;
    end

    // ---------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int ch = 0; ch < CHANNELS; ch++) begin
                r_chan_state[ch] <= acd_pkg::ST_CLEAR;
                r_chan_count[ch] <= '0;
                r_prev_level[ch] <= 1'b0;
                r_prev_seen[ch]  <= 1'b0;
            end
            r_last_chan    <= '0;
            r_last_valid   <= 1'b0;
            r_ready_total  <= '0;
            r_hold_timer   <= '0;
            r_buzzer_timer <= '0;
            r_led          <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_fire) begin
                r_chan_state   <= n_chan_state;
                r_chan_count   <= n_chan_count;
                r_prev_level   <= n_prev_level;
                r_prev_seen    <= n_prev_seen;
                r_last_chan    <= n_last_chan;
                r_last_valid   <= n_last_valid;
                r_ready_total  <= n_ready_total;
                r_hold_timer   <= n_hold_timer;
                r_buzzer_timer <= n_buzzer_timer;
                r_led          <= n_led;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_cmd  <= i_in.command;
            r_in_bits <= i_in.contact_bits;
            r_in_en   <= i_in.remote_enable;
        end
        if (w_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.channel_states  = r_out.channel_states;
    assign o_out.new_alarm_mask  = r_out.new_alarm_mask;
    assign o_out.alarm_key_event = r_out.alarm_key_event;
    assign o_out.led_on          = r_out.led_on;
    assign o_out.buzzer_left     = r_out.buzzer_left;
    assign o_out.hold_left       = r_out.hold_left;
    assign o_out.ready_count     = r_out.ready_count;

    // ---------------------------------------------------------- assertions
    // State moves only when an item is retired into the output register.
    `ACD_ASSERT_NXT(a_state_held_on_stall, i_clk, i_rst_n, !w_fire, $stable(r_hold_timer) && $stable(r_ready_total) && $stable(r_led))
    // A clear-all item always reports every channel clear.
    `ACD_ASSERT_NXT(a_clear_all_result, i_clk, i_rst_n, w_fire && r_in_cmd == acd_pkg::CMD_CLEAR, r_out.channel_states == '0)
    // A ready channel lights the LED, and the LED only goes out with the count.
    `ACD_ASSERT_IMP(a_ready_implies_led, i_clk, i_rst_n, r_ready_total != '0, r_led)
    // The LED cannot be cleared while any channel is set.
    `ACD_ASSERT_IMP(a_set_implies_led, i_clk, i_rst_n, w_any_set, r_led)

endmodule

`default_nettype wire
